FILE: src/kwr_pkg.sv
// ----------------------------------------------------------------------------
// kwr_pkg: keyword recogniser shared definitions
// Types, character constants and the reserved word table used by the
// word collector and the matcher.
// ----------------------------------------------------------------------------
package kwr_pkg;

   localparam int MaxKeywordLenDefault = 9;
   localparam int KwCount              = 46;
   localparam int KwMin                = 2;
   localparam int KwMax                = 9;
   localparam int CodeWidth            = 6;

   localparam logic [7:0] UpperA     = 8'd65;
   localparam logic [7:0] UpperZ     = 8'd90;
   localparam logic [7:0] CaseOffset = 8'd32;

   // Text packed right-justified: character i of a word of length L sits at
   // bits [(L-1-i)*8 +: 8].
   localparam logic [KwMax*8-1:0] KwText [KwCount] = '{
      "do", "if", "in", "of", "or", "to",
      "and", "div", "end", "for", "mod", "nil", "not", "set", "var",
      "byte", "case", "char", "else", "file", "goto", "real", "then",
      "true", "type", "with", "word",
      "array", "begin", "const", "false", "label", "until", "while",
      "downto", "packed", "record", "repeat",
      "boolean", "integer", "longint", "program",
      "cardinal", "function", "shortint",
      "procedure"
   };

   localparam int KwLen [KwCount] = '{
      2, 2, 2, 2, 2, 2,
      3, 3, 3, 3, 3, 3, 3, 3, 3,
      4, 4, 4, 4, 4, 4, 4, 4,
      4, 4, 4, 4,
      5, 5, 5, 5, 5, 5, 5,
      6, 6, 6, 6,
      7, 7, 7, 7,
      8, 8, 8,
      9
   };

   // Status of the completed word waiting for lookup
   typedef struct packed {
      logic valid;
      logic too_long;
   } snap_ctl_type;

endpackage

FILE: src/kwr_if.sv
// ----------------------------------------------------------------------------
// kwr_req_if / kwr_rsp_if: keyword recogniser channels
// Valid/ready channels for incoming characters and outgoing token codes.
// ----------------------------------------------------------------------------
interface kwr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       word_last;

   modport source (output valid, output char_byte, output word_last, input ready);
   modport sink   (input valid, input char_byte, input word_last, output ready);
endinterface

interface kwr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [kwr_pkg::CodeWidth-1:0] token_code;
   logic                         is_reserved;

   modport source (output valid, output token_code, output is_reserved, input ready);
   modport sink   (input valid, input token_code, input is_reserved, output ready);
endinterface

FILE: src/kwr_collect.sv
// ----------------------------------------------------------------------------
// kwr_collect: word collector
// Folds case, stores the bytes of the current word and hands a finished
// word to the matcher through a snapshot register.
// ----------------------------------------------------------------------------
module kwr_collect #(
   parameter  int MaxKeywordLen = kwr_pkg::MaxKeywordLenDefault,
   localparam int LenW          = $clog2(MaxKeywordLen + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   kwr_req_if.sink                          req_chan,
   input  logic                             advance,
   output kwr_pkg::snap_ctl_type            snap_ctl,
   output logic [MaxKeywordLen-1:0][7:0]    snap_word,
   output logic [LenW-1:0]                  snap_len
);

   logic [MaxKeywordLen-1:0][7:0] store_ff, store_in;
   logic [LenW-1:0]               len_ff, len_in;
   logic                          long_ff, long_in;
   logic [MaxKeywordLen-1:0][7:0] snap_word_ff;
   logic [LenW-1:0]               snap_len_ff, snap_len_in;
   logic                          snap_long_ff, snap_long_in;
   logic                          snap_valid_ff, snap_valid_in;
   logic                          accept;
   logic                          has_room;
   logic [7:0]                    char_fold;

   assign req_chan.ready = !snap_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;
   assign has_room       = len_ff < LenW'(MaxKeywordLen);

   always_comb begin
      char_fold = req_chan.char_byte;
      if (req_chan.char_byte >= kwr_pkg::UpperA && req_chan.char_byte <= kwr_pkg::UpperZ) begin
         char_fold = req_chan.char_byte + kwr_pkg::CaseOffset;
      end
      for (int i = 0; i < MaxKeywordLen; i++) begin
         store_in[i] = (has_room && len_ff == LenW'(i)) ? char_fold : store_ff[i];
      end
      snap_len_in  = has_room ? len_ff + LenW'(1) : len_ff;
      snap_long_in = long_ff || !has_room;

      len_in        = len_ff;
      long_in       = long_ff;
      snap_valid_in = advance ? 1'b0 : snap_valid_ff;
      if (accept) begin
         if (req_chan.word_last) begin
            len_in        = '0;
            long_in       = 1'b0;
            snap_valid_in = 1'b1;
         end else begin
            len_in  = snap_len_in;
            long_in = snap_long_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         long_ff       <= 1'b0;
         snap_valid_ff <= 1'b0;
      end else begin
         len_ff        <= len_in;
         long_ff       <= long_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   // Payload: no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         store_ff <= store_in;
      end
      if (accept && req_chan.word_last) begin
         snap_word_ff <= store_in;
         snap_len_ff  <= snap_len_in;
         snap_long_ff <= snap_long_in;
      end
   end

   assign snap_ctl.valid    = snap_valid_ff;
   assign snap_ctl.too_long = snap_long_ff;
   assign snap_word         = snap_word_ff;
   assign snap_len          = snap_len_ff;

endmodule

FILE: src/kwr_match.sv
// ----------------------------------------------------------------------------
// kwr_match: reserved word matcher
// Compares the finished word with every reserved word in parallel and
// holds the token code in the result register.
// ----------------------------------------------------------------------------
module kwr_match #(
   parameter  int MaxKeywordLen = kwr_pkg::MaxKeywordLenDefault,
   localparam int LenW          = $clog2(MaxKeywordLen + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  kwr_pkg::snap_ctl_type            snap_ctl,
   input  logic [MaxKeywordLen-1:0][7:0]    snap_word,
   input  logic [LenW-1:0]                  snap_len,
   output logic                             advance,
   kwr_rsp_if.source                        rsp_chan
);

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [kwr_pkg::CodeWidth-1:0]  code_ff, code_in;
   logic                           hit;

   always_comb begin
      code_in = '0;
      // Walk the table backwards so the earliest entry wins
      for (int k = kwr_pkg::KwCount - 1; k >= 0; k--) begin
         hit = (snap_len == LenW'(kwr_pkg::KwLen[k]));
         for (int i = 0; i < kwr_pkg::KwMax; i++) begin
            if (i < kwr_pkg::KwLen[k]) begin
               if (snap_word[i] != kwr_pkg::KwText[k][(kwr_pkg::KwLen[k] - 1 - i) * 8 +: 8]) begin
                  hit = 1'b0;
               end
            end
         end
         if (hit) begin
            code_in = kwr_pkg::CodeWidth'(k + 1);
         end
      end
      if (snap_ctl.too_long || snap_len < LenW'(kwr_pkg::KwMin)
          || snap_len > LenW'(kwr_pkg::KwMax)) begin
         code_in = '0;
      end
   end

   assign advance      = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_valid_in = advance ? snap_ctl.valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && snap_ctl.valid) begin
         code_ff <= code_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.token_code  = code_ff;
   assign rsp_chan.is_reserved = (code_ff != '0);

endmodule

FILE: src/keyword_recognizer_unit.sv
// ----------------------------------------------------------------------------
// keyword_recognizer_unit: reserved word lookup
// Takes one word as a stream of characters and returns one token code per
// word: 0 for an identifier, 1..46 for a reserved word in table order.
//
// Channels: req_chan carries one character per item (char_byte) with
// word_last set on the final character; rsp_chan carries one item per word
// (token_code, is_reserved). Both are valid/ready; an item moves on a rising
// edge with valid and ready high.
// Throughput: one character per cycle while rsp_chan takes tokens, including
// back-to-back words; the collector, a snapshot register and the result
// register each hold one stage, so a new word starts while the previous
// one is still being looked up. The snapshot register takes the word at
// the edge that accepts its final character; the parallel compare then
// loads the result register, which offers the token on rsp_chan.
// Stall: while rsp_chan is held off the result stays put; the next finished
// word waits in the snapshot register, and once both are full req_chan.ready
// drops for every character until rsp_chan.ready returns.
// Reset (synchronous, active high): empties both stages and clears the
// length count and overflow mark; the character store needs no clearing.
// ----------------------------------------------------------------------------
module keyword_recognizer_unit #(
   parameter int MaxKeywordLen = kwr_pkg::MaxKeywordLenDefault
) (
   input  logic       clock,
   input  logic       reset,
   kwr_req_if.sink    req_chan,
   kwr_rsp_if.source  rsp_chan
);

   localparam int LenW = $clog2(MaxKeywordLen + 1);

   kwr_pkg::snap_ctl_type          snap_ctl;
   logic [MaxKeywordLen-1:0][7:0]  snap_word;
   logic [LenW-1:0]                snap_len;
   logic                           advance;

   // Fold case, hold the word, snapshot it on the final character
   kwr_collect #(
      .MaxKeywordLen (MaxKeywordLen)
   ) u_collect (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .advance   (advance),
      .snap_ctl  (snap_ctl),
      .snap_word (snap_word),
      .snap_len  (snap_len)
   );

   // Compare against the table and register the token
   kwr_match #(
      .MaxKeywordLen (MaxKeywordLen)
   ) u_match (
      .clock     (clock),
      .reset     (reset),
      .snap_ctl  (snap_ctl),
      .snap_word (snap_word),
      .snap_len  (snap_len),
      .advance   (advance),
      .rsp_chan  (rsp_chan)
   );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: keyword recogniser testbench
// Streams words into keyword_recognizer_unit one character per item and
// compares every token code against a local word collector and table
// lookup, or a pinned code. A short directed table covers case folding,
// the shortest and longest keywords, a single-character word, bytes
// outside the letters and an overlong word. A long random run of keywords,
// near misses and noise follows under varying idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int KeywordCount = 46;
   localparam int StoreDepth   = 9;
   localparam int ShortestWord = 2;
   localparam int LongestWord  = 9;
   localparam int TotalChars   = 1950;
   localparam int CycleLimit   = 200000;
   localparam int DrainCycles  = 8;

   // Token codes named in the directed table
   localparam logic [5:0] TokIdent     = 6'd0;
   localparam logic [5:0] TokDo        = 6'd1;
   localparam logic [5:0] TokProcedure = 6'd46;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       pinned;   // token typed in below rather than predicted
      logic [5:0] code;
   } stim_row_type;

   typedef struct packed {
      logic [5:0] code;
      logic       reserved;
   } token_rec_type;

   // Directed characters: mixed-case "Do", upper-case "PROCEDURE", a lone
   // 0xFF, a zero byte followed by '@', then "procedures" (one past the store)
   localparam int DirectedLen = 24;
   localparam stim_row_type DirectedRows [DirectedLen] = '{
      '{"D", 1'b0, 1'b0, TokIdent}, '{"o", 1'b1, 1'b1, TokDo},
      '{"P", 1'b0, 1'b0, TokIdent}, '{"R", 1'b0, 1'b0, TokIdent},
      '{"O", 1'b0, 1'b0, TokIdent}, '{"C", 1'b0, 1'b0, TokIdent},
      '{"E", 1'b0, 1'b0, TokIdent}, '{"D", 1'b0, 1'b0, TokIdent},
      '{"U", 1'b0, 1'b0, TokIdent}, '{"R", 1'b0, 1'b0, TokIdent},
      '{"E", 1'b1, 1'b1, TokProcedure},
      '{8'hFF, 1'b1, 1'b1, TokIdent},
      '{8'h00, 1'b0, 1'b0, TokIdent}, '{"@", 1'b1, 1'b1, TokIdent},
      '{"p", 1'b0, 1'b0, TokIdent}, '{"r", 1'b0, 1'b0, TokIdent},
      '{"o", 1'b0, 1'b0, TokIdent}, '{"c", 1'b0, 1'b0, TokIdent},
      '{"e", 1'b0, 1'b0, TokIdent}, '{"d", 1'b0, 1'b0, TokIdent},
      '{"u", 1'b0, 1'b0, TokIdent}, '{"r", 1'b0, 1'b0, TokIdent},
      '{"e", 1'b0, 1'b0, TokIdent}, '{"s", 1'b1, 1'b1, TokIdent}
   };

   // Reserved words in code order: entry k has token code k+1
   string reserved_words [KeywordCount] = '{
      "do", "if", "in", "of", "or", "to",
      "and", "div", "end", "for", "mod", "nil", "not", "set", "var",
      "byte", "case", "char", "else", "file", "goto", "real", "then",
      "true", "type", "with", "word",
      "array", "begin", "const", "false", "label", "until", "while",
      "downto", "packed", "record", "repeat",
      "boolean", "integer", "longint", "program",
      "cardinal", "function", "shortint",
      "procedure"
   };

   logic clock = 1'b0;
   logic reset;

   kwr_req_if req ();
   kwr_rsp_if rsp ();

   keyword_recognizer_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp)
   );

   // Word collector mirror: folded characters, count and overflow mark
   logic [7:0] held_chars [StoreDepth];
   int         held_count;
   logic       held_overflow;

   token_rec_type expected_tokens [$];
   logic [7:0]    word_chars [$];

   int send_idle_pct;
   int take_idle_pct;
   int cycle_count;
   int mismatch_count;
   int chars_sent;
   int words_sent;
   int overlong_words;
   int tokens_seen;
   int reserved_seen;

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog: give up well past the slowest legal run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Timed out after %0d cycles with %0d tokens pending",
                  cycle_count, expected_tokens.size());
         $display("FAIL");
         $finish;
      end
   end

   // Result side back-pressure: drop ready at random per the current phase
   always @(posedge clock) begin
      rsp.ready <= ($urandom_range(0, 99) >= take_idle_pct);
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Match the held word against the table; 0 means identifier
   function automatic logic [5:0] look_up_held();
      logic hit;
      if (held_overflow || held_count < ShortestWord || held_count > LongestWord)
         return TokIdent;
      for (int k = 0; k < KeywordCount; k++) begin
         if (reserved_words[k].len() == held_count) begin
            hit = 1'b1;
            for (int i = 0; i < held_count; i++)
               if (held_chars[i] != reserved_words[k][i]) hit = 1'b0;
            if (hit) return 6'(k + 1);
         end
      end
      return TokIdent;
   endfunction

   // Fold one accepted character into the mirror; on the last one produce the token
   task automatic collect_char(input logic [7:0] c, input logic last,
                               output logic has_token, output token_rec_type token);
      logic [7:0] folded;
      folded = c;
      if (c >= "A" && c <= "Z") folded = c + 8'd32;
      if (held_count < StoreDepth) begin
         held_chars[held_count] = folded;
         held_count++;
      end else begin
         held_overflow = 1'b1;
      end
      has_token = last;
      token = '0;
      if (last) begin
         token.code = look_up_held();
         token.reserved = (token.code != TokIdent);
         if (held_overflow) overlong_words++;
         held_count = 0;
         held_overflow = 1'b0;
      end
   endtask

   // Offer one character, hold it until taken, then record what it should cause
   task automatic send_char(input logic [7:0] c, input logic last,
                            input logic pinned, input logic [5:0] pin_code);
      logic          has_token;
      token_rec_type token;
      // Decide afresh at each clock whether to idle, so the idle share matches the phase
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.char_byte <= c;
      req.word_last <= last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      collect_char(c, last, has_token, token);
      if (has_token) begin
         if (pinned) begin
            token.code = pin_code;
            token.reserved = (pin_code != TokIdent);
         end
         expected_tokens.push_back(token);
         words_sent++;
      end
      chars_sent++;
   endtask

   function automatic logic [7:0] random_alnum();
      case ($urandom_range(0, 2))
         0: return "0" + 8'($urandom_range(0, 9));
         1: return "A" + 8'($urandom_range(0, 25));
         default: return "a" + 8'($urandom_range(0, 25));
      endcase
   endfunction

   // Fill word_chars with a keyword in random case
   task automatic pick_keyword();
      string      kw;
      logic [7:0] c;
      kw = reserved_words[$urandom_range(0, KeywordCount - 1)];
      word_chars.delete();
      for (int i = 0; i < kw.len(); i++) begin
         c = kw[i];
         if ($urandom_range(0, 1) == 1) c = c - 8'd32;
         word_chars.push_back(c);
      end
   endtask

   // Build the next random word: mostly keywords and near misses, some noise
   task automatic build_word();
      int kind;
      int n;
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
         pick_keyword();
      end else if (kind < 55) begin
         // near miss: one character swapped
         pick_keyword();
         word_chars[$urandom_range(0, word_chars.size() - 1)] = random_alnum();
      end else if (kind < 65) begin
         // truncate or extend a keyword by a character or two
         pick_keyword();
         n = $urandom_range(1, 2);
         if ($urandom_range(0, 1) == 1) begin
            repeat (n) word_chars.push_back(random_alnum());
         end else begin
            repeat (n) if (word_chars.size() > 1) void'(word_chars.pop_back());
         end
      end else if (kind < 85) begin
         word_chars.delete();
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 14) : $urandom_range(2, 9);
         repeat (n) word_chars.push_back(random_alnum());
      end else if (kind < 92) begin
         // keyword with one arbitrary byte dropped in
         pick_keyword();
         word_chars[$urandom_range(0, word_chars.size() - 1)] = 8'($urandom_range(0, 255));
      end else begin
         word_chars.delete();
         repeat ($urandom_range(1, 11)) word_chars.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   // Hold the sender until every outstanding token has come back
   task automatic drain_tokens();
      req.valid <= 1'b0;
      @(posedge clock);
      while (expected_tokens.size() != 0) @(posedge clock);
   endtask

   // Check each delivered token against the oldest expectation
   always @(posedge clock) begin : token_check
      token_rec_type due;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_tokens.size() == 0) begin
            report_mismatch("token with nothing pending", rsp.token_code, -1);
         end else begin
            due = expected_tokens.pop_front();
            if (rsp.token_code !== due.code)
               report_mismatch("token_code", rsp.token_code, due.code);
            if (rsp.is_reserved !== due.reserved)
               report_mismatch("is_reserved", rsp.is_reserved, due.reserved);
            tokens_seen++;
            if (due.reserved) reserved_seen++;
         end
      end
   end

   initial begin
      int phase;
      // Known values on every input from time zero
      reset         = 1'b1;
      req.valid     = 1'b0;
      req.char_byte = 8'h00;
      req.word_last = 1'b0;
      rsp.ready     = 1'b0;
      cycle_count    = 0;
      mismatch_count = 0;
      chars_sent     = 0;
      words_sent     = 0;
      overlong_words = 0;
      tokens_seen    = 0;
      reserved_seen  = 0;
      held_count     = 0;
      held_overflow  = 1'b0;
      send_idle_pct  = 28;
      take_idle_pct  = 56;
      phase          = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table first
      foreach (DirectedRows[r])
         send_char(DirectedRows[r].ch, DirectedRows[r].last,
                   DirectedRows[r].pinned, DirectedRows[r].code);

      // Random words; switch idle pattern by thirds, draining at each switch
      while (chars_sent < TotalChars) begin
         if (phase == 0 && chars_sent >= TotalChars / 3) begin
            drain_tokens();
            send_idle_pct = 56;
            take_idle_pct = 28;
            phase = 1;
         end else if (phase == 1 && chars_sent >= (2 * TotalChars) / 3) begin
            drain_tokens();
            send_idle_pct = 0;
            take_idle_pct = 0;
            phase = 2;
         end
         build_word();
         foreach (word_chars[i])
            send_char(word_chars[i], i == word_chars.size() - 1, 1'b0, TokIdent);
      end

      // Drop valid, wait out every token and the pipeline tail
      req.valid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Sent %0d characters in %0d words (%0d overlong); checked %0d tokens,",
               chars_sent, words_sent, overlong_words, tokens_seen);
      $display("%0d of them reserved words, with %0d mismatches", reserved_seen,
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/kwr_pkg.sv
src/kwr_if.sv
src/kwr_collect.sv
src/kwr_match.sv
src/keyword_recognizer_unit.sv
verif/tb_top.sv
